/* hdl/mec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mec_pkg;

  localparam int CoordW = 32;
  localparam int IterW  = 16;
  localparam int FracW  = 28;
  // internal value width; all intermediate values stay below 2^48
  localparam int IntW   = 52;
  // multiplier magnitude width and chunking of operand b
  localparam int MagW   = 48;
  localparam int ChunkW = 16;
  localparam int NChunk = MagW / ChunkW;
  localparam int ProdW  = 2 * MagW;
  localparam int UidxW  = 4;
  localparam logic signed [IntW-1:0] EscLim = IntW'(64'sd4 <<< FracW);
  localparam logic signed [IntW-1:0] CoordMax = IntW'((64'sd1 <<< (CoordW - 1)) - 1);
  localparam logic signed [IntW-1:0] CoordMin = -CoordMax - IntW'(1);

  localparam logic [0:0] RegMaxIter = 1'b0;
  localparam logic [0:0] RegDegree  = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [IntW-1:0]   ival_t;

  typedef enum logic [2:0] {
    SRC_X, SRC_Y, SRC_R2, SRC_I2, SRC_R4, SRC_I4, SRC_T
  } src_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_R2, DST_I2, DST_R4, DST_I4, DST_T
  } dst_e;

  typedef enum logic [1:0] {
    ACC_NONE, ACC_RE, ACC_IM
  } acc_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_STEP, ST_DONE
  } state_e;

  typedef struct packed {
    src_e              a;
    src_e              b;
    dst_e              dst;
    acc_e              acc;
    logic signed [4:0] coef;
    logic              last;
  } uop_t;

  function automatic uop_t mk(src_e a, src_e b, dst_e dst, acc_e acc,
                              logic signed [4:0] coef, logic last);
    uop_t u;
    u.a = a; u.b = b; u.dst = dst; u.acc = acc; u.coef = coef; u.last = last;
    return u;
  endfunction

  // microcode: one product per entry; deg code 0..3 stands for degree 2..5
  function automatic uop_t uop_get(logic [1:0] deg, logic [UidxW-1:0] idx);
    uop_t u;
    u = mk(SRC_X, SRC_X, DST_NONE, ACC_NONE, 5'sd0, 1'b1);
    case ({deg, idx})
      {2'd0, 4'd0}:  u = mk(SRC_X, SRC_X, DST_R2, ACC_RE, 5'sd1, 1'b0);
      {2'd0, 4'd1}:  u = mk(SRC_Y, SRC_Y, DST_I2, ACC_RE, -5'sd1, 1'b0);
      {2'd0, 4'd2}:  u = mk(SRC_X, SRC_Y, DST_NONE, ACC_IM, -5'sd2, 1'b1);

      {2'd1, 4'd0}:  u = mk(SRC_X, SRC_X, DST_R2, ACC_NONE, 5'sd0, 1'b0);
      {2'd1, 4'd1}:  u = mk(SRC_Y, SRC_Y, DST_I2, ACC_NONE, 5'sd0, 1'b0);
      {2'd1, 4'd2}:  u = mk(SRC_X, SRC_R2, DST_NONE, ACC_RE, 5'sd1, 1'b0);
      {2'd1, 4'd3}:  u = mk(SRC_X, SRC_I2, DST_NONE, ACC_RE, -5'sd3, 1'b0);
      {2'd1, 4'd4}:  u = mk(SRC_Y, SRC_R2, DST_NONE, ACC_IM, -5'sd3, 1'b0);
      {2'd1, 4'd5}:  u = mk(SRC_Y, SRC_I2, DST_NONE, ACC_IM, 5'sd1, 1'b1);

      {2'd2, 4'd0}:  u = mk(SRC_X, SRC_X, DST_R2, ACC_NONE, 5'sd0, 1'b0);
      {2'd2, 4'd1}:  u = mk(SRC_Y, SRC_Y, DST_I2, ACC_NONE, 5'sd0, 1'b0);
      {2'd2, 4'd2}:  u = mk(SRC_R2, SRC_X, DST_T, ACC_NONE, 5'sd0, 1'b0);
      {2'd2, 4'd3}:  u = mk(SRC_T, SRC_Y, DST_NONE, ACC_IM, -5'sd4, 1'b0);
      {2'd2, 4'd4}:  u = mk(SRC_X, SRC_I2, DST_T, ACC_NONE, 5'sd0, 1'b0);
      {2'd2, 4'd5}:  u = mk(SRC_T, SRC_Y, DST_NONE, ACC_IM, 5'sd4, 1'b0);
      {2'd2, 4'd6}:  u = mk(SRC_R2, SRC_R2, DST_NONE, ACC_RE, 5'sd1, 1'b0);
      {2'd2, 4'd7}:  u = mk(SRC_R2, SRC_I2, DST_NONE, ACC_RE, -5'sd6, 1'b0);
      {2'd2, 4'd8}:  u = mk(SRC_I2, SRC_I2, DST_NONE, ACC_RE, 5'sd1, 1'b1);

      {2'd3, 4'd0}:  u = mk(SRC_X, SRC_X, DST_R2, ACC_NONE, 5'sd0, 1'b0);
      {2'd3, 4'd1}:  u = mk(SRC_Y, SRC_Y, DST_I2, ACC_NONE, 5'sd0, 1'b0);
      {2'd3, 4'd2}:  u = mk(SRC_R2, SRC_R2, DST_R4, ACC_NONE, 5'sd0, 1'b0);
      {2'd3, 4'd3}:  u = mk(SRC_I2, SRC_I2, DST_I4, ACC_NONE, 5'sd0, 1'b0);
      {2'd3, 4'd4}:  u = mk(SRC_R4, SRC_X, DST_NONE, ACC_RE, 5'sd1, 1'b0);
      {2'd3, 4'd5}:  u = mk(SRC_X, SRC_R2, DST_T, ACC_NONE, 5'sd0, 1'b0);
      {2'd3, 4'd6}:  u = mk(SRC_T, SRC_I2, DST_NONE, ACC_RE, -5'sd10, 1'b0);
      {2'd3, 4'd7}:  u = mk(SRC_X, SRC_I4, DST_NONE, ACC_RE, 5'sd5, 1'b0);
      {2'd3, 4'd8}:  u = mk(SRC_R4, SRC_Y, DST_NONE, ACC_IM, -5'sd5, 1'b0);
      {2'd3, 4'd9}:  u = mk(SRC_R2, SRC_I2, DST_T, ACC_NONE, 5'sd0, 1'b0);
      {2'd3, 4'd10}: u = mk(SRC_T, SRC_Y, DST_NONE, ACC_IM, 5'sd10, 1'b0);
      {2'd3, 4'd11}: u = mk(SRC_I4, SRC_Y, DST_NONE, ACC_IM, -5'sd1, 1'b1);
      default:       u = mk(SRC_X, SRC_X, DST_NONE, ACC_NONE, 5'sd0, 1'b1);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

/* hdl/mec_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface mec_in_if;
  logic                    valid;
  logic                    ready;
  mec_pkg::coord_t         c_re;
  mec_pkg::coord_t         c_im;
  mec_pkg::coord_t         start_z_re;
  mec_pkg::coord_t         start_z_im;
  logic [mec_pkg::IterW-1:0] start_iter;

  modport source (output valid, c_re, c_im, start_z_re, start_z_im, start_iter,
                  input ready);
  modport sink (input valid, c_re, c_im, start_z_re, start_z_im, start_iter,
                output ready);
endinterface

interface mec_out_if;
  logic                    valid;
  logic                    ready;
  logic [mec_pkg::IterW:0] iterations;
  mec_pkg::coord_t         end_z_re;
  mec_pkg::coord_t         end_z_im;
  logic                    escaped;

  modport source (output valid, iterations, end_z_re, end_z_im, escaped,
                  input ready);
  modport sink (input valid, iterations, end_z_re, end_z_im, escaped,
                output ready);
endinterface
`default_nettype wire

/* hdl/mec_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module mec_cfg (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [2:0]                paddr,
  input  wire logic [31:0]               pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [mec_pkg::IterW-1:0]      max_iter_o,
  output logic [1:0]                     deg_code_o
);
  import mec_pkg::*;

  logic [IterW-1:0] max_iter_q;
  logic [2:0]       degree_q;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= IterW'(256);
      degree_q   <= 3'd2;
    end else if (wr_en) begin
      case (paddr[2])
        RegMaxIter: max_iter_q <= pwdata[IterW-1:0];
        RegDegree:  degree_q   <= pwdata[2:0];
        default:    ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      RegMaxIter: prdata = 32'(max_iter_q);
      RegDegree:  prdata = 32'(degree_q);
      default:    prdata = '0;
    endcase
  end

  // degree below 2 acts as 2, above 5 as 5
  always_comb begin
    if (degree_q < 3'd2)      deg_code_o = 2'd0;
    else if (degree_q > 3'd5) deg_code_o = 2'd3;
    else                      deg_code_o = 2'(degree_q - 3'd2);
  end

  assign max_iter_o = max_iter_q;
endmodule
`default_nettype wire

/* hdl/mec_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module mec_mul (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire mec_pkg::ival_t  a_i,
  input  wire mec_pkg::ival_t  b_i,
  output logic                 done_o,
  output mec_pkg::ival_t       p_o
);
  import mec_pkg::*;

  logic [MagW-1:0]           ma_q, mb_q;
  logic [ProdW-1:0]          acc_q;
  logic                      neg_q;
  logic [1:0]                cnt_q;
  logic                      busy_q, done_q;
  logic [MagW+ChunkW-1:0]    pp;
  logic [ProdW-1:0]          pp_sh;
  ival_t                     mag;

  // one 48x16 partial product per cycle, low chunk of b first
  assign pp    = ma_q * mb_q[ChunkW-1:0];
  assign pp_sh = ProdW'(pp) << {cnt_q, 4'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'(NChunk - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= MagW'(a_i[IntW-1] ? -a_i : a_i);
      mb_q  <= MagW'(b_i[IntW-1] ? -b_i : b_i);
      neg_q <= a_i[IntW-1] ^ b_i[IntW-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
      mb_q  <= mb_q >> ChunkW;
    end
  end

  // magnitude truncated toward zero, then signed
  assign mag    = acc_q[FracW +: IntW];
  assign p_o    = neg_q ? -mag : mag;
  assign done_o = done_q;
endmodule
`default_nettype wire

/* hdl/multicorn_escape_iteration_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Each step runs P products, P = 3, 6, 9, 12 for degree 2..5; one step per
// iteration run, plus two more steps after an escape.
// One pixel at a time: a new pixel is taken only while idle. The shared 48x16
// multiplier, with issue and handoff around each product, sets the cost. A
// pixel starting at or past the limit runs no step and goes straight to done.
// Reset (rst_ni low, async): idle, no result held, max_iterations 256, degree 2.
module multicorn_escape_iteration_core (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  mec_in_if.sink        in_if,
  mec_out_if.source     out_if,
  input  wire logic     psel,
  input  wire logic     penable,
  input  wire logic     pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import mec_pkg::*;

  logic [IterW-1:0] max_iter;
  logic [1:0]       deg_code;

  state_e           state_q, state_d;
  coord_t           cr_q, cr_d, ci_q, ci_d, x_q, x_d, y_q, y_d;
  ival_t            r2_q, r2_d, i2_q, i2_d, r4_q, r4_d, i4_q, i4_d, t_q, t_d;
  ival_t            are_q, are_d, aim_q, aim_d;
  logic [IterW:0]   iter_q, iter_d;
  logic             esc_q, esc_d;
  logic [1:0]       extra_q, extra_d;
  logic [UidxW-1:0] uidx_q, uidx_d;
  logic [1:0]       deg_q, deg_d;

  logic             ov_q, ov_d;
  logic [IterW:0]   o_iter_q, o_iter_d;
  coord_t           o_re_q, o_re_d, o_im_q, o_im_d;
  logic             o_esc_q, o_esc_d;

  uop_t             uop;
  ival_t            op_a, op_b, prod;
  logic             mul_start, mul_done;
  logic signed [IntW+4:0] term;
  ival_t            mag2;
  coord_t           zr_new, zi_new;
  logic [IterW:0]   iter_inc;

  mec_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .max_iter_o (max_iter),
    .deg_code_o (deg_code)
  );

  mec_mul u_mul (
    .clk_i, .rst_ni,
    .start_i (mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .p_o     (prod)
  );

  function automatic ival_t pick(src_e s, coord_t x, coord_t y, ival_t r2, ival_t i2,
                                 ival_t r4, ival_t i4, ival_t t);
    ival_t v;
    case (s)
      SRC_X:   v = IntW'(x);
      SRC_Y:   v = IntW'(y);
      SRC_R2:  v = r2;
      SRC_I2:  v = i2;
      SRC_R4:  v = r4;
      SRC_I4:  v = i4;
      SRC_T:   v = t;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic coord_t sat(ival_t v);
    coord_t r;
    if (v > CoordMax)      r = CoordMax[CoordW-1:0];
    else if (v < CoordMin) r = CoordMin[CoordW-1:0];
    else                   r = v[CoordW-1:0];
    return r;
  endfunction

  // operand selection and per-product datapath
  assign uop      = uop_get(deg_q, uidx_q);
  assign op_a     = pick(uop.a, x_q, y_q, r2_q, i2_q, r4_q, i4_q, t_q);
  assign op_b     = pick(uop.b, x_q, y_q, r2_q, i2_q, r4_q, i4_q, t_q);
  assign term     = prod * uop.coef;
  assign mag2     = r2_q + i2_q;
  assign zr_new   = sat(are_q);
  assign zi_new   = sat(aim_q);
  assign iter_inc = iter_q + (IterW+1)'(1);

  assign in_if.ready       = (state_q == ST_IDLE);
  assign out_if.valid      = ov_q;
  assign out_if.iterations = o_iter_q;
  assign out_if.end_z_re   = o_re_q;
  assign out_if.end_z_im   = o_im_q;
  assign out_if.escaped    = o_esc_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    cr_d = cr_q; ci_d = ci_q; x_d = x_q; y_d = y_q;
    r2_d = r2_q; i2_d = i2_q; r4_d = r4_q; i4_d = i4_q; t_d = t_q;
    are_d = are_q; aim_d = aim_q;
    iter_d = iter_q; esc_d = esc_q; extra_d = extra_q;
    uidx_d = uidx_q; deg_d = deg_q;
    ov_d = ov_q & ~out_if.ready;
    o_iter_d = o_iter_q; o_re_d = o_re_q; o_im_d = o_im_q; o_esc_d = o_esc_q;
    mul_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          cr_d    = in_if.c_re;
          ci_d    = in_if.c_im;
          x_d     = in_if.start_z_re;
          y_d     = in_if.start_z_im;
          iter_d  = (IterW+1)'(in_if.start_iter);
          esc_d   = 1'b0;
          extra_d = '0;
          deg_d   = deg_code;
          are_d   = IntW'(in_if.c_re);
          aim_d   = IntW'(in_if.c_im);
          uidx_d  = '0;
          if (in_if.start_iter >= max_iter) state_d = ST_DONE;
          else                              state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mul_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done) begin
          case (uop.dst)
            DST_R2:  r2_d = prod;
            DST_I2:  i2_d = prod;
            DST_R4:  r4_d = prod;
            DST_I4:  i4_d = prod;
            DST_T:   t_d  = prod;
            default: ;
          endcase
          case (uop.acc)
            ACC_RE:  are_d = are_q + IntW'(term);
            ACC_IM:  aim_d = aim_q + IntW'(term);
            default: ;
          endcase
          if (uop.last) begin
            state_d = ST_STEP;
          end else begin
            uidx_d  = uidx_q + UidxW'(1);
            state_d = ST_ISSUE;
          end
        end
      end
      ST_STEP: begin
        // close one step: new z, escape test on the squares of the old z
        x_d     = zr_new;
        y_d     = zi_new;
        are_d   = IntW'(cr_q);
        aim_d   = IntW'(ci_q);
        uidx_d  = '0;
        state_d = ST_ISSUE;
        if (extra_q != 2'd0) begin
          extra_d = extra_q - 2'd1;
          if (extra_q == 2'd1) state_d = ST_DONE;
        end else if (mag2 > EscLim) begin
          esc_d   = 1'b1;
          iter_d  = iter_q + (IterW+1)'(2);
          extra_d = 2'd2;
        end else begin
          iter_d = iter_inc;
          if (iter_inc >= (IterW+1)'(max_iter)) state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_q || out_if.ready) begin
          ov_d     = 1'b1;
          o_iter_d = iter_q;
          o_re_d   = x_q;
          o_im_d   = y_q;
          o_esc_d  = esc_q;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      extra_q <= '0;
      uidx_q  <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      extra_q <= extra_d;
      uidx_q  <= uidx_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cr_q <= cr_d; ci_q <= ci_d; x_q <= x_d; y_q <= y_d;
    r2_q <= r2_d; i2_q <= i2_d; r4_q <= r4_d; i4_q <= i4_d; t_q <= t_d;
    are_q <= are_d; aim_q <= aim_d;
    iter_q <= iter_d; esc_q <= esc_d; deg_q <= deg_d;
    o_iter_q <= o_iter_d; o_re_q <= o_re_d; o_im_q <= o_im_d; o_esc_q <= o_esc_d;
  end
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import mec_pkg::*;

  localparam longint IntLim  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam longint EscThr  = 64'sd4 <<< FracW;
  localparam longint Span2p5 = 64'sd671088640;   // 2.5 in Q4.28
  localparam longint One     = 64'sd1 <<< FracW;
  localparam int     IdleLim = 40000;

  typedef struct {
    coord_t            c_re;
    coord_t            c_im;
    coord_t            z_re;
    coord_t            z_im;
    logic [IterW-1:0]  start_iter;
  } pixel_t;

  typedef struct {
    logic [IterW:0] iters;
    coord_t         z_re;
    coord_t         z_im;
    logic           escaped;
  } escape_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mec_in_if  pix_in ();
  mec_out_if pix_out ();

  multicorn_escape_iteration_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (pix_in),
    .out_if  (pix_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the block's registers
  int unsigned    cfg_max_iter;
  logic [2:0]     cfg_degree;
  escape_res_t    pending_res[$];
  int             err_count;
  int             burst_left;
  int             idle_cycles;
  logic [15:0]    stall_lfsr;
  int unsigned    cyc_count;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------
  // Fixed-point escape-time predictor
  // ---------------------------------------------------------------------
  function automatic longint lim_clamp(longint x);
    if (x > IntLim) return IntLim;
    if (x < -IntLim) return -IntLim;
    return x;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return lim_clamp(a + b);
  endfunction

  function automatic longint scale_int(longint x, longint k);
    if (x > IntLim / k) return IntLim;
    if (x < -(IntLim / k)) return -IntLim;
    return x * k;
  endfunction

  // exact product, magnitude truncated by the fraction bits, saturated
  function automatic longint fx_mul(longint a, longint b);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    longint       r;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    p   = ({64'd0, ma} * {64'd0, mb}) >> FracW;
    if (p > 128'(IntLim)) r = IntLim;
    else r = longint'(p[63:0]);
    return neg ? -r : r;
  endfunction

  function automatic longint coord_clip(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // one step of z := conj(z)^d + c; returns |z|^2 before the step
  function automatic longint conj_power_step(inout longint zr, inout longint zi,
                                             input longint cr, input longint ci,
                                             input int d);
    longint x, y, re2, im2, nr, ni, t, re4, im4;
    x   = zr;
    y   = zi;
    re2 = fx_mul(x, x);
    im2 = fx_mul(y, y);
    case (d)
      2: begin
        ni = sat_add(-scale_int(fx_mul(x, y), 2), ci);
        nr = sat_add(sat_add(re2, -im2), cr);
      end
      3: begin
        nr = sat_add(sat_add(fx_mul(x, re2), -scale_int(fx_mul(x, im2), 3)), cr);
        ni = sat_add(sat_add(-scale_int(fx_mul(y, re2), 3), fx_mul(y, im2)), ci);
      end
      4: begin
        t  = sat_add(fx_mul(fx_mul(re2, x), y), -fx_mul(fx_mul(x, im2), y));
        ni = sat_add(-scale_int(t, 4), ci);
        nr = sat_add(sat_add(sat_add(fx_mul(re2, re2),
                                     -scale_int(fx_mul(re2, im2), 6)),
                             fx_mul(im2, im2)), cr);
      end
      default: begin
        re4 = fx_mul(re2, re2);
        im4 = fx_mul(im2, im2);
        nr  = sat_add(sat_add(sat_add(fx_mul(re4, x),
                                      -scale_int(fx_mul(fx_mul(x, re2), im2), 10)),
                              scale_int(fx_mul(x, im4), 5)), cr);
        ni  = sat_add(sat_add(sat_add(-scale_int(fx_mul(re4, y), 5),
                                      scale_int(fx_mul(fx_mul(re2, im2), y), 10)),
                              -fx_mul(im4, y)), ci);
      end
    endcase
    zr = coord_clip(nr);
    zi = coord_clip(ni);
    return sat_add(re2, im2);
  endfunction

  function automatic escape_res_t predict_escape(pixel_t px, int unsigned lim,
                                                 logic [2:0] deg_reg);
    longint      cr, ci, zr, zi, mag;
    int unsigned it;
    int          d;
    escape_res_t r;
    cr = px.c_re;
    ci = px.c_im;
    zr = px.z_re;
    zi = px.z_im;
    d  = (deg_reg < 3'd2) ? 2 : ((deg_reg > 3'd5) ? 5 : int'(deg_reg));
    it = px.start_iter;
    r.escaped = 1'b0;
    while (it < lim) begin
      mag = conj_power_step(zr, zi, cr, ci, d);
      if (mag > EscThr) begin
        mag = conj_power_step(zr, zi, cr, ci, d);
        mag = conj_power_step(zr, zi, cr, ci, d);
        it += 2;
        r.escaped = 1'b1;
        break;
      end
      it++;
    end
    r.iters = it[IterW:0];
    r.z_re  = coord_t'(zr);
    r.z_im  = coord_t'(zi);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, longint exp_v, longint got_v);
    $display("%0t ERROR %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    escape_res_t e;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result beat, iterations", -1,
                        longint'(pix_out.iterations));
      end else begin
        e = pending_res.pop_front();
        if (pix_out.iterations !== e.iters)
          report_mismatch("iterations", e.iters, pix_out.iterations);
        if (pix_out.end_z_re !== e.z_re)
          report_mismatch("end_z_re", e.z_re, pix_out.end_z_re);
        if (pix_out.end_z_im !== e.z_im)
          report_mismatch("end_z_im", e.z_im, pix_out.end_z_im);
        if (pix_out.escaped !== e.escaped)
          report_mismatch("escaped", e.escaped, pix_out.escaped);
      end
    end
  end

  // receiver stalls: LFSR pattern, with free-running stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
      stall_lfsr    <= 16'hACE1;
      cyc_count     <= 0;
    end else begin
      stall_lfsr    <= {stall_lfsr[14:0],
                        stall_lfsr[15] ^ stall_lfsr[13] ^ stall_lfsr[12] ^ stall_lfsr[10]};
      cyc_count     <= cyc_count + 1;
      pix_out.ready <= cyc_count[10] | (stall_lfsr[2:0] != 3'b000 && !stall_lfsr[7]);
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk_i) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLim) begin
      $display("tb_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic cfg_write(logic [0:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegMaxIter) cfg_max_iter = val[IterW-1:0];
    else cfg_degree = val[2:0];
  endtask

  // sender pauses until every pending result has come back
  task automatic drain_results();
    pix_in.valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_config(int unsigned max_it, logic [2:0] deg);
    drain_results();
    cfg_write(RegMaxIter, 32'(max_it));
    cfg_write(RegDegree, 32'(deg));
  endtask

  // send one pixel beat; bursts of random length with random gaps
  task automatic send_pixel(pixel_t px);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    pix_in.valid      <= 1'b1;
    pix_in.c_re       <= px.c_re;
    pix_in.c_im       <= px.c_im;
    pix_in.start_z_re <= px.z_re;
    pix_in.start_z_im <= px.z_im;
    pix_in.start_iter <= px.start_iter;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    pending_res.push_back(predict_escape(px, cfg_max_iter, cfg_degree));
  endtask

  function automatic pixel_t fresh_pixel(longint cr, longint ci);
    pixel_t px;
    px.c_re = coord_t'(cr);
    px.c_im = coord_t'(ci);
    px.z_re = coord_t'(cr);
    px.z_im = coord_t'(ci);
    px.start_iter = 1;
    return px;
  endfunction

  function automatic pixel_t make_pixel(longint cr, longint ci, longint zr, longint zi,
                                        int unsigned it);
    pixel_t px;
    px.c_re = coord_t'(cr);
    px.c_im = coord_t'(ci);
    px.z_re = coord_t'(zr);
    px.z_im = coord_t'(zi);
    px.start_iter = it[IterW-1:0];
    return px;
  endfunction

  function automatic longint near_coord(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // mostly well-formed pixels near the set, the rest resumed or noise
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     kind;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      px = fresh_pixel(near_coord(Span2p5), near_coord(Span2p5));
      if (kind == 0) px.start_iter = 0;
    end else if (kind < 8) begin
      px = make_pixel(near_coord(Span2p5), near_coord(Span2p5),
                      near_coord(2 * One), near_coord(2 * One),
                      $urandom_range(0, cfg_max_iter + 2));
    end else begin
      px = make_pixel(longint'(coord_t'($urandom)), longint'(coord_t'($urandom)),
                      longint'(coord_t'($urandom)), longint'(coord_t'($urandom)),
                      (kind == 8) ? $urandom_range(0, 65535) : $urandom_range(0, 3));
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_pixel(fresh_pixel(0, 0));
    send_pixel(fresh_pixel(-2 * One, 0));
    send_pixel(fresh_pixel(64'sd2147483647, 64'sd2147483647));
    send_pixel(fresh_pixel(-64'sd2147483648, -64'sd2147483648));
    send_pixel(make_pixel(0, 0, 64'sd2147483647, -64'sd2147483648, 0));
    send_pixel(make_pixel(One / 4, One / 8, 0, 0, 255));
    send_pixel(make_pixel(One / 4, One / 8, 0, 0, 256));
    send_pixel(make_pixel(One, One, One, One, 65535));
  endtask

  task automatic test_limit_extremes();
    set_config(65535, 3'd2);
    send_pixel(make_pixel(0, 0, 0, 0, 65534));
    send_pixel(make_pixel(One * 3, One, One * 3, One, 65534));
    send_pixel(make_pixel(One * 3, One, One * 3, One, 65535));
    set_config(0, 3'd3);
    send_pixel(fresh_pixel(One * 3, One));
    send_pixel(make_pixel(One, -One, One, -One, 0));
  endtask

  task automatic test_all_degrees();
    for (int d = 0; d < 8; d++) begin
      set_config(4, 3'(d));
      send_pixel(fresh_pixel(One / 4, One / 10));
      send_pixel(fresh_pixel(One * 3 / 2, -One * 3 / 2));
      send_pixel(make_pixel(-64'sd2147483648, 64'sd2147483647,
                            64'sd2147483647, -64'sd2147483648, 0));
    end
  endtask

  task automatic test_random_pixels();
    for (int ph = 0; ph < 10; ph++) begin
      set_config((ph == 3) ? 1 : $urandom_range(1, 32),
                 (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7)));
      for (int n = 0; n < 100; n++) begin
        send_pixel(random_pixel());
        if (ph == 5 && n == 50) drain_results();
      end
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    pix_in.valid      <= 1'b0;
    pix_in.c_re       <= '0;
    pix_in.c_im       <= '0;
    pix_in.start_z_re <= '0;
    pix_in.start_z_im <= '0;
    pix_in.start_iter <= '0;
    err_count    = 0;
    burst_left   = 0;
    cfg_max_iter = 256;
    cfg_degree   = 3'd2;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_limit_extremes();
    test_all_degrees();
    test_random_pixels();

    drain_results();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/mec_pkg.sv
hdl/mec_if.sv
hdl/mec_cfg.sv
hdl/mec_mul.sv
hdl/multicorn_escape_iteration_core.sv
tb/sv/tb_top.sv
